FILE: hw/rtl/slot_countdown_delay_table_top_defines.svh
// ----------------------------------------------------------------------------
// Slot countdown delay table: assertion macros
// Concurrent check macros used by the top level, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLOT_COUNTDOWN_DELAY_TABLE_TOP_DEFINES_SVH
`define SLOT_COUNTDOWN_DELAY_TABLE_TOP_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define SCDT_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define SCDT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/scdt_pkg.sv
// ----------------------------------------------------------------------------
// Slot countdown delay table: shared package
// Sizes, action codes and the records passed between the block's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scdt_pkg;

    localparam int SLOT_COUNT  = 256;
    localparam int SLOT_AW     = $clog2(SLOT_COUNT);
    localparam int ID_WIDTH    = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int RELOAD_WIDTH = 32;
    // One table entry is the armed flag above the remaining count.
    localparam int ENTRY_WIDTH = COUNT_WIDTH + 1;
    // Result queue depth covers the word in the engine plus two queued words.
    localparam int RES_DEPTH   = 3;
    localparam int RES_PW      = $clog2(RES_DEPTH);
    localparam int RES_CW      = $clog2(RES_DEPTH + 1);

    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic started;
        logic expired;
    } t_result;

    typedef struct packed {
        logic    vld;
        t_result res;
    } t_res_push;

endpackage

FILE: hw/rtl/scdt_in_if.sv
// ----------------------------------------------------------------------------
// Slot countdown delay table: input channel
// Valid/ready channel carrying one slot command word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface scdt_in_if import scdt_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [ID_WIDTH-1:0]     slot_id;
    logic [RELOAD_WIDTH-1:0] reload_count;

    modport source (output valid, output action, output slot_id, output reload_count,
                    input ready);
    modport sink   (input valid, input action, input slot_id, input reload_count,
                    output ready);

endinterface

FILE: hw/rtl/scdt_out_if.sv
// ----------------------------------------------------------------------------
// Slot countdown delay table: result channel
// Valid/ready channel carrying one result word of two flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface scdt_out_if import scdt_pkg::*; ();

    logic valid;
    logic ready;
    logic started;
    logic expired;

    modport source (output valid, output started, output expired, input ready);
    modport sink   (input valid, input started, input expired, output ready);

endinterface

FILE: hw/rtl/scdt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/scdt_engine.sv
// ----------------------------------------------------------------------------
// Slot countdown delay table: slot update engine
// Reads the addressed slot entry, applies the step or clear, writes the entry
// back and emits the result flags. Back-to-back hits on one slot are served
// from a one-deep forwarding register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scdt_engine import scdt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_action,
    input  logic [ID_WIDTH-1:0]     i_slot_id,
    input  logic [RELOAD_WIDTH-1:0] i_reload_count,
    output logic                    o_busy,
    output t_res_push               o_push
);

    // Update stage registers.
    logic                    r_s1_vld;
    logic                    r_s1_act;
    logic                    r_s1_inr;
    logic [SLOT_AW-1:0]      r_s1_slot;
    logic [COUNT_WIDTH-1:0]  r_s1_reload;

    // Per-slot written flags; an unwritten entry reads as idle with zero count.
    logic [SLOT_COUNT-1:0]   r_vbits;

    // Last write, for a read that raced it in the RAM.
    logic                    r_fwd_vld;
    logic [SLOT_AW-1:0]      r_fwd_addr;
    logic [ENTRY_WIDTH-1:0]  r_fwd_data;

    logic [ENTRY_WIDTH-1:0]  w_rdata;
    logic [ENTRY_WIDTH-1:0]  w_cur;
    logic                    w_armed;
    logic [COUNT_WIDTH-1:0]  w_rem;
    logic                    w_we;
    logic [ENTRY_WIDTH-1:0]  w_wdata;
    logic                    w_started;
    logic                    w_expired;
    logic                    w_in_range;

    assign w_in_range = ({1'b0, i_slot_id} < (ID_WIDTH + 1)'(SLOT_COUNT));

    scdt_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s1_slot),
        .i_wdata (w_wdata),
        .i_re    (i_accept),
        .i_raddr (i_slot_id[SLOT_AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_slot)) begin
            w_cur = r_fwd_data;
        end else if (r_vbits[r_s1_slot]) begin
            w_cur = w_rdata;
        end else begin
            w_cur = '0;
        end
        w_armed = w_cur[COUNT_WIDTH];
        w_rem   = w_cur[COUNT_WIDTH-1:0];

        w_we      = r_s1_vld && r_s1_inr;
        w_wdata   = w_cur;
        w_started = 1'b0;
        w_expired = 1'b0;
        priority if (r_s1_act == ACT_CLEAR) begin
            w_wdata = '0;
        end else if (!w_armed) begin
            // Arm; a reload of two or less leaves nothing to count down.
            w_wdata   = {1'b1, (r_s1_reload != '0) ? (r_s1_reload - COUNT_WIDTH'(1)) : '0};
            w_started = 1'b1;
        end else if (w_rem > COUNT_WIDTH'(1)) begin
            w_wdata = {1'b1, w_rem - COUNT_WIDTH'(1)};
        end else begin
            w_wdata   = {1'b0, w_rem};
            w_expired = 1'b1;
        end
        if (!r_s1_inr) begin
            w_started = 1'b0;
            w_expired = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_vbits   <= '0;
        end else begin
            r_s1_vld  <= i_accept;
            r_fwd_vld <= w_we;
            if (w_we) begin
                r_vbits[r_s1_slot] <= 1'b1;
            end
        end
        if (i_accept) begin
            r_s1_act    <= i_action;
            r_s1_inr    <= w_in_range;
            r_s1_slot   <= i_slot_id[SLOT_AW-1:0];
            r_s1_reload <= i_reload_count[COUNT_WIDTH-1:0];
        end
        r_fwd_addr <= r_s1_slot;
        r_fwd_data <= w_wdata;
    end

    assign o_busy          = r_s1_vld;
    assign o_push.vld      = r_s1_vld;
    assign o_push.res      = '{started: w_started, expired: w_expired};

endmodule

FILE: hw/rtl/scdt_rfifo.sv
// ----------------------------------------------------------------------------
// Slot countdown delay table: result queue
// Small flop-based queue between the engine and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scdt_rfifo import scdt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_res_push         i_push,
    output logic [RES_CW-1:0] o_count,
    scdt_out_if.source        o_out
);

    t_result           r_mem [RES_DEPTH];
    logic [RES_PW-1:0] r_rd_ptr;
    logic [RES_PW-1:0] r_wr_ptr;
    logic [RES_CW-1:0] r_count;
    logic [RES_PW-1:0] n_rd_ptr;
    logic [RES_PW-1:0] n_wr_ptr;
    logic [RES_CW-1:0] n_count;
    logic              w_pop;

    assign w_pop = o_out.valid && o_out.ready;

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == RES_PW'(RES_DEPTH - 1)) ? '0 : r_rd_ptr + RES_PW'(1);
        end
        if (i_push.vld) begin
            n_wr_ptr = (r_wr_ptr == RES_PW'(RES_DEPTH - 1)) ? '0 : r_wr_ptr + RES_PW'(1);
        end
        n_count = r_count + RES_CW'(i_push.vld) - RES_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
        if (i_push.vld) begin
            r_mem[r_wr_ptr] <= i_push.res;
        end
    end

    assign o_count       = r_count;
    assign o_out.valid   = (r_count != '0);
    assign o_out.started = r_mem[r_rd_ptr].started;
    assign o_out.expired = r_mem[r_rd_ptr].expired;

endmodule

FILE: hw/rtl/slot_countdown_delay_table_top.sv
// Path: engine update stage register, then the result queue, then o_out.
// Throughput: one word per cycle while the result queue has room, set by the
//   single read-modify-write of the slot RAM; a hit on the slot written the
//   cycle before is forwarded.
// Reset: synchronous, active low; all slots read as idle right after reset,
//   with no clearing pass, and in-flight results are dropped.
// ----------------------------------------------------------------------------
// Slot countdown delay table: top level
// A table of independent countdown slots held in a RAM. A step arms an idle
// slot (flagging started), counts an armed slot down, or disarms a slot whose
// count has run out (flagging expired). A clear disarms the slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slot_countdown_delay_table_top_defines.svh"

module slot_countdown_delay_table_top import scdt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scdt_in_if.sink     i_in,
    scdt_out_if.source  o_out
);

    logic                w_accept;
    logic                w_busy;
    t_res_push           w_push;
    logic [RES_CW-1:0]   w_count;
    logic [RES_CW:0]     w_fill;

    // Every word in the engine will land in the result queue next cycle, so
    // a new word is taken only while the queue plus the engine leave room.
    // This depends on registered state alone, never on o_out.ready.
    assign w_fill     = {1'b0, w_count} + (RES_CW + 1)'(w_busy);
    assign i_in.ready = (w_fill < (RES_CW + 1)'(RES_DEPTH));
    assign w_accept   = i_in.valid && i_in.ready;

    // The engine reads the slot entry in the accept cycle and writes it back
    // in the following cycle, together with the result flags.
    scdt_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_action       (i_in.action),
        .i_slot_id      (i_in.slot_id),
        .i_reload_count (i_in.reload_count),
        .o_busy         (w_busy),
        .o_push         (w_push)
    );

    // The result queue decouples the result channel from the input side.
    scdt_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_count (w_count),
        .o_out   (o_out)
    );

    // The queue never overflows: queued words plus the word in flight fit.
    `SCDT_CHECK_NOW(a_fill_bound, 1'b1, w_fill <= (RES_CW + 1)'(RES_DEPTH), "result queue overrun")
    // An accepted word is in the engine at the next edge.
    `SCDT_CHECK_NEXT(a_accept_busy, w_accept, w_busy, "accepted word lost before update")
    // A result finished into an empty queue is offered on the next cycle.
    `SCDT_CHECK_NEXT(a_result_shown, w_busy && (w_count == '0), o_out.valid,
        "finished result not offered")

endmodule

FILE: tb/sv/scdt_flag_monitor.sv
// ----------------------------------------------------------------------------
// Slot countdown delay table: result flag monitor
// Watches both channels, keeps its own copy of the slot table, predicts the
// flags of every accepted command word and compares each result word with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scdt_flag_monitor import scdt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    scdt_in_if   i_cmd,
    scdt_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    logic                   slot_live [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0] slot_left [SLOT_COUNT];
    t_result                pending_flags [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_live[i] = 1'b0;
            slot_left[i] = '0;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    // Applies one command word to the local slot table and returns its flags.
    function automatic t_result step_slot_table(input logic act,
                                                input logic [ID_WIDTH-1:0] sid,
                                                input logic [RELOAD_WIDTH-1:0] reload);
        t_result                flags;
        logic [COUNT_WIDTH-1:0] count;
        flags = '0;
        count = COUNT_WIDTH'(reload);
        if (int'(sid) < SLOT_COUNT) begin
            if (act == ACT_CLEAR) begin
                slot_live[sid] = 1'b0;
                slot_left[sid] = '0;
            end else if (!slot_live[sid]) begin
                slot_live[sid] = 1'b1;
                slot_left[sid] = (count != '0) ? count - 1'b1 : '0;
                flags.started  = 1'b1;
            end else if (slot_left[sid] > 1) begin
                slot_left[sid] = slot_left[sid] - 1'b1;
            end else begin
                // The count is left as it is; the next arming overwrites it.
                slot_live[sid] = 1'b0;
                flags.expired  = 1'b1;
            end
        end
        return flags;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            // A result word can never belong to a command accepted at the same
            // edge, so the result side is handled first.
            if (i_res.valid && i_res.ready) begin
                if (pending_flags.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected (s=%0b e=%0b)",
                                              i_res.started, i_res.expired));
                end else begin
                    want = pending_flags.pop_front();
                    if (i_res.started !== want.started) begin
                        report_mismatch($sformatf("started is %0b, expected %0b",
                                                  i_res.started, want.started));
                    end
                    if (i_res.expired !== want.expired) begin
                        report_mismatch($sformatf("expired is %0b, expected %0b",
                                                  i_res.expired, want.expired));
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                pending_flags.push_back(step_slot_table(i_cmd.action, i_cmd.slot_id,
                                                        i_cmd.reload_count));
            end
            o_pending = pending_flags.size();
        end
    end

endmodule

FILE: tb/sv/tb_slot_countdown_delay_table_top.sv
// ----------------------------------------------------------------------------
// Slot countdown delay table: testbench top
// Drives command words into the slot table under several idle and stall
// patterns, lets the flag monitor predict and compare the result words, and
// gives the verdict once every expected result word has arrived.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_slot_countdown_delay_table_top;
    import scdt_pkg::*;

    // Cycles with no word accepted on either channel before the run is
    // declared hung. Random stalls at 48 percent almost never last anywhere
    // near this long, so the limit leaves a wide margin.
    localparam int HANG_LIMIT   = 2000;
    // The tail pause outlasts the path from a command word through the update
    // stage and the result queue, so a stray extra word is still seen.
    localparam int TAIL_CYCLES  = 12;
    localparam int RESET_CYCLES = 11;
    localparam int PHASE_WORDS  = 185;

    logic i_clk;
    logic i_rst_n;

    // Percentages of cycles in which the sender holds back a word and the
    // receiver refuses one. They change from phase to phase.
    int sender_idle_pct;
    int recv_stall_pct;

    int fail_count;
    int pending;

    scdt_in_if  in_ch ();
    scdt_out_if out_ch ();

    slot_countdown_delay_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    scdt_flag_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // The receiver decides afresh at every falling edge whether it takes a
    // result word at the next rising edge. With a zero stall rate it is
    // always ready, which gives stretches of full throughput.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Hang detection: any accepted word on either side restarts the count.
    // The run ends here only if the block stops moving altogether.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("timeout: no word accepted for %0d cycles", HANG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Presents one command word, first holding valid low for a random number
    // of cycles according to the sender idle rate. The task is entered and
    // left at a falling edge; valid stays high across back-to-back words.
    task automatic send_word(input logic act,
                             input logic [ID_WIDTH-1:0] sid,
                             input logic [RELOAD_WIDTH-1:0] reload);
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            in_ch.valid        <= 1'b0;
            in_ch.action       <= 1'($urandom());
            in_ch.slot_id      <= ID_WIDTH'($urandom());
            in_ch.reload_count <= $urandom();
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.slot_id      <= sid;
        in_ch.reload_count <= reload;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Most random words step a small group of neighboring slots, mostly with short
    // reload counts, so slots run through arm, count-down and expiry many
    // times. Some words clear a slot in that group, and the rest hit any
    // slot with a full-width reload count to exercise every field bit.
    task automatic send_random_word(input int hot_base);
        int                      pick;
        logic                    act;
        logic [ID_WIDTH-1:0]     sid;
        logic [RELOAD_WIDTH-1:0] reload;
        pick = $urandom_range(0, 99);
        act  = ACT_STEP;
        sid  = ID_WIDTH'(hot_base + $urandom_range(0, 5));
        if ($urandom_range(0, 9) < 7) begin
            reload = $urandom_range(0, 4);
        end else begin
            reload = $urandom();
        end
        if (pick < 9) begin
            act = ACT_CLEAR;
        end else if (pick >= 82) begin
            sid    = ID_WIDTH'($urandom());
            reload = $urandom();
            if (pick >= 94) begin
                act = ACT_CLEAR;
            end
        end
        send_word(act, sid, reload);
    endtask

    initial begin
        int phase_idx;
        int word_idx;
        int hot_base;

        // Every input is known from time zero; reset is held for the first
        // cycles and never asserted again.
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_STEP;
        in_ch.slot_id      = '0;
        in_ch.reload_count = '0;
        out_ch.ready       = 1'b0;
        sender_idle_pct    = 0;
        recv_stall_pct     = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words, sent with no idling so that steps on the same slot
        // come back to back and rely on the write forwarding in the block.
        // A zero reload arms slot zero, which must work, then expires it.
        send_word(ACT_STEP,  8'd0,   32'd0);
        send_word(ACT_STEP,  8'd0,   32'd7);
        // A reload of one behaves like zero: the very next step expires.
        send_word(ACT_STEP,  8'd255, 32'd1);
        send_word(ACT_STEP,  8'd255, 32'd0);
        // A reload of three counts down once before the expiring step.
        send_word(ACT_STEP,  8'd1,   32'd3);
        send_word(ACT_STEP,  8'd1,   32'hFFFF_FFFF);
        send_word(ACT_STEP,  8'd1,   32'd0);
        send_word(ACT_STEP,  8'd1,   32'd2);
        // Largest reload, a count-down step, then a clear of the armed slot
        // and a re-arm that must start again.
        send_word(ACT_STEP,  8'd2,   32'hFFFF_FFFF);
        send_word(ACT_STEP,  8'd2,   32'd0);
        send_word(ACT_CLEAR, 8'd2,   32'hFFFF_FFFF);
        send_word(ACT_STEP,  8'd2,   32'd2);
        send_word(ACT_STEP,  8'd2,   32'd0);
        // Clearing an idle slot changes nothing and flags nothing.
        send_word(ACT_CLEAR, 8'd128, 32'd0);
        send_word(ACT_STEP,  8'd128, 32'h8000_0000);
        send_word(ACT_STEP,  8'd128, 32'h5555_5555);
        send_word(ACT_CLEAR, 8'd0,   32'hAAAA_AAAA);
        send_word(ACT_STEP,  8'd0,   32'd5);
        send_word(ACT_CLEAR, 8'd0,   32'd0);
        send_word(ACT_STEP,  8'd0,   32'd0);
        send_word(ACT_STEP,  8'd0,   32'd0);
        // Alternating slots keep the forwarding path from masking a stale
        // read of the other slot.
        send_word(ACT_STEP,  8'd170, 32'd2);
        send_word(ACT_STEP,  8'd85,  32'd2);
        send_word(ACT_STEP,  8'd170, 32'd0);
        send_word(ACT_STEP,  8'd85,  32'd0);

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
            case (phase_idx)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 48;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 48;
                end
                default: begin
                    sender_idle_pct = 18;
                    recv_stall_pct  = 18;
                end
            endcase
            for (word_idx = 0; word_idx < PHASE_WORDS; word_idx++) begin
                // Move the hot group now and then, reaching both table ends.
                if (word_idx % 60 == 0) begin
                    hot_base = $urandom_range(0, SLOT_COUNT - 6);
                end
                send_random_word(hot_base);
            end
        end
        in_ch.valid <= 1'b0;

        // Drain: the hang detector bounds this wait.
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
